// ----- rtl/rgrt_pkg.sv -----
`timescale 1ns / 1ps
package rgrt_pkg;

	localparam int MAX_CELLS_DEF = 64;
	localparam int CFG_W = 7;
	localparam logic [31:0] MAX_LEN = 32'hFFFF_FFFF;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_STEP = 2'd2;

	localparam logic [1:0] REG_CELLS_X = 2'd0;
	localparam logic [1:0] REG_CELLS_Y = 2'd1;
	localparam logic [1:0] REG_CELLS_Z = 2'd2;

	typedef enum logic [1:0] {
		LEN_DIV,
		LEN_ZERO,
		LEN_MAX
	} len_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_CLAMP,
		ST_WRD,
		ST_DIVGO,
		ST_DIVW,
		ST_SEL,
		ST_MUL,
		ST_ADD
	} state_t;

	typedef struct packed {
		logic       accept_load;
		logic       accept_start;
		logic       emit_zero;
		logic       srch_rd;
		logic       srch_cmp;
		logic       srch_fin;
		logic       clamp;
		logic       div_go;
		logic       sel;
		logic       mul;
		logic       add;
		logic [1:0] adv;
	} cmd_t;

	typedef struct packed {
		logic walk_active;
		logic srch_done;
		logic div_done;
	} sts_t;

endpackage

// ----- rtl/rgrt_div.sv -----
`timescale 1ns / 1ps
module rgrt_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  rgrt_pkg::len_mode_t mode,
	input  logic [32:0]         mag,
	input  logic [31:0]         den,
	output logic                done,
	output logic [31:0]         len
);

	logic                run_q;
	logic [5:0]          cnt_q;
	logic [31:0]         rem_q;
	logic [31:0]         shf_q;
	logic [31:0]         den_q;
	logic [31:0]         quo_q;
	rgrt_pkg::len_mode_t mode_q;
	logic [32:0]         rem2;
	logic                qbit;

	always_comb begin
		rem2 = {rem_q, shf_q[31]};
		qbit = (rem2 >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (run_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				run_q <= 1'b0;
			end
		end
	end

	// dividend is mag << 30; quotient known to fit 32 bits
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= {1'b0, mag[32:2]};
			shf_q  <= {mag[1:0], 30'd0};
			den_q  <= den;
			quo_q  <= '0;
			mode_q <= mode;
		end else if (run_q) begin
			rem_q <= qbit ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
			shf_q <= {shf_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], qbit};
		end
	end

	always_comb begin
		case (mode_q)
			rgrt_pkg::LEN_MAX:  len = rgrt_pkg::MAX_LEN;
			rgrt_pkg::LEN_ZERO: len = '0;
			default:            len = quo_q;
		endcase
	end

	assign done = !run_q;

endmodule

// ----- rtl/rgrt_dp.sv -----
`timescale 1ns / 1ps
module rgrt_dp #(
	parameter int N = rgrt_pkg::MAX_CELLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rgrt_pkg::cmd_t      cmd,
	output rgrt_pkg::sts_t      sts,
	input  logic [6:0]          cells_x,
	input  logic [6:0]          cells_y,
	input  logic [6:0]          cells_z,
	input  logic [1:0]          axis,
	input  logic [6:0]          edge_slot,
	input  logic [31:0]         edge_coord,
	input  logic [31:0]         start_x,
	input  logic [31:0]         start_y,
	input  logic [31:0]         start_z,
	input  logic [31:0]         dir_x,
	input  logic [31:0]         dir_y,
	input  logic [31:0]         dir_z,
	output logic                done,
	output logic                segment_valid,
	output logic [17:0]         cell_number,
	output logic [31:0]         segment_length,
	output logic                exited
);

	localparam int CW = $clog2(N + 1);

	logic [6:0]          raw [3];
	logic [CW-1:0]       n [3];
	logic [31:0]         pos_q [3];
	logic [31:0]         dir_q [3];
	logic [CW-1:0]       cell_q [3];
	logic [CW-1:0]       lo_q [3];
	logic [CW-1:0]       hi_q [3];
	logic [CW-1:0]       mid [3];
	logic [CW-1:0]       raddr [3];
	logic [2:0]          sdone;
	logic                active_q;
	logic [31:0]         rdata_q [3];
	logic [31:0]         wall_q [3];
	logic [31:0]         dabs [3];
	logic signed [32:0]  diff [3];
	logic [32:0]         mag [3];
	rgrt_pkg::len_mode_t mode [3];
	logic [31:0]         lens [3];
	logic [2:0]          ldone;
	logic [31:0]         cn;
	logic [17:0]         cellnum_s1;
	logic [1:0]          sel;
	logic [1:0]          sel_q;
	logic [31:0]         len_q;
	logic [63:0]         prod_s1;
	logic [33:0]         dstep;
	logic signed [35:0]  radv;
	logic [31:0]         rsat;
	logic                kneg;
	logic                exit_now;
	logic [31:0]         start_in [3];
	logic [31:0]         dir_in [3];

	always_comb begin
		raw[0] = cells_x;
		raw[1] = cells_y;
		raw[2] = cells_z;
		start_in[0] = start_x;
		start_in[1] = start_y;
		start_in[2] = start_z;
		dir_in[0] = dir_x;
		dir_in[1] = dir_y;
		dir_in[2] = dir_z;
		for (int a = 0; a < 3; a++) begin
			if (raw[a] == '0) begin
				n[a] = CW'(1);
			end else if (32'(raw[a]) > N) begin
				n[a] = CW'(N);
			end else begin
				n[a] = CW'(raw[a]);
			end
			mid[a]   = CW'(({1'b0, lo_q[a]} + {1'b0, hi_q[a]}) >> 1);
			sdone[a] = ({1'b0, hi_q[a]} <= {1'b0, lo_q[a]} + (CW + 1)'(1));
			raddr[a] = cmd.srch_rd ? mid[a]
			         : (dir_q[a][31] ? cell_q[a] : cell_q[a] + CW'(1));
			dabs[a]  = dir_q[a][31] ? 32'(-dir_q[a]) : dir_q[a];
			diff[a]  = $signed({rdata_q[a][31], rdata_q[a]}) - $signed({pos_q[a][31], pos_q[a]});
			mag[a]   = diff[a][32] ? 33'(-diff[a]) : 33'(diff[a]);
			if (dir_q[a] == '0) begin
				mode[a] = rgrt_pkg::LEN_MAX;
			end else if (diff[a] == '0 || diff[a][32] != dir_q[a][31]) begin
				mode[a] = rgrt_pkg::LEN_ZERO;
			end else if ({1'b0, mag[a]} >= {dabs[a], 2'b00}) begin
				mode[a] = rgrt_pkg::LEN_MAX;
			end else begin
				mode[a] = rgrt_pkg::LEN_DIV;
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_ax
		logic [31:0] mem [0:N];

		always_ff @(posedge clk) begin
			if (cmd.accept_load && axis == 2'(g) && 32'(edge_slot) <= N) begin
				mem[CW'(edge_slot)] <= edge_coord;
			end
			rdata_q[g] <= mem[raddr[g]];
		end

		rgrt_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.go     (cmd.div_go),
			.mode   (mode[g]),
			.mag    (mag[g]),
			.den    (dabs[g]),
			.done   (ldone[g]),
			.len    (lens[g])
		);
	end

	always_comb begin
		cn = 32'(cell_q[2]) + 32'(n[2]) * (32'(cell_q[1]) + 32'(n[1]) * 32'(cell_q[0]));
		if (lens[0] <= lens[1] && lens[0] <= lens[2]) begin
			sel = 2'd0;
		end else if (lens[1] < lens[0] && lens[1] <= lens[2]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
		kneg = dir_q[sel][31];
		exit_now = kneg ? (cell_q[sel] == '0)
		                : ({1'b0, cell_q[sel]} + (CW + 1)'(1) >= {1'b0, n[sel]});
		dstep = prod_s1[63:30];
		if (dir_q[cmd.adv][31]) begin
			radv = $signed({{4{pos_q[cmd.adv][31]}}, pos_q[cmd.adv]}) - $signed({2'b00, dstep});
		end else begin
			radv = $signed({{4{pos_q[cmd.adv][31]}}, pos_q[cmd.adv]}) + $signed({2'b00, dstep});
		end
		if (radv > 36'sd2147483647) begin
			rsat = 32'h7FFF_FFFF;
		end else if (radv < -36'sd2147483648) begin
			rsat = 32'h8000_0000;
		end else begin
			rsat = radv[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			done           <= 1'b0;
			segment_valid  <= 1'b0;
			cell_number    <= '0;
			segment_length <= '0;
			exited         <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				pos_q[a]  <= '0;
				dir_q[a]  <= '0;
				cell_q[a] <= '0;
				lo_q[a]   <= '0;
				hi_q[a]   <= '0;
			end
		end else begin
			done <= cmd.emit_zero | cmd.sel;
			if (cmd.emit_zero) begin
				segment_valid  <= 1'b0;
				cell_number    <= '0;
				segment_length <= '0;
				exited         <= 1'b0;
			end
			if (cmd.accept_start) begin
				for (int a = 0; a < 3; a++) begin
					pos_q[a] <= start_in[a];
					dir_q[a] <= dir_in[a];
					lo_q[a]  <= '0;
					hi_q[a]  <= n[a];
				end
			end
			if (cmd.srch_cmp) begin
				for (int a = 0; a < 3; a++) begin
					if (!sdone[a]) begin
						if ($signed(pos_q[a]) < $signed(rdata_q[a])) begin
							hi_q[a] <= mid[a];
						end else begin
							lo_q[a] <= mid[a];
						end
					end
				end
			end
			if (cmd.srch_fin) begin
				active_q <= 1'b1;
				for (int a = 0; a < 3; a++) begin
					cell_q[a] <= lo_q[a];
				end
			end
			if (cmd.clamp) begin
				for (int a = 0; a < 3; a++) begin
					if (cell_q[a] >= n[a]) begin
						cell_q[a] <= n[a] - CW'(1);
					end
				end
			end
			if (cmd.sel) begin
				segment_valid  <= 1'b1;
				cell_number    <= cellnum_s1;
				segment_length <= lens[sel];
				exited         <= exit_now;
				if (exit_now) begin
					active_q <= 1'b0;
				end else if (kneg) begin
					cell_q[sel] <= cell_q[sel] - CW'(1);
				end else begin
					cell_q[sel] <= cell_q[sel] + CW'(1);
				end
			end
			if (cmd.add) begin
				pos_q[cmd.adv] <= (cmd.adv == sel_q) ? wall_q[cmd.adv] : rsat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			cellnum_s1 <= cn[17:0];
			for (int a = 0; a < 3; a++) begin
				wall_q[a] <= rdata_q[a];
			end
		end
		if (cmd.sel) begin
			sel_q <= sel;
			len_q <= lens[sel];
		end
		if (cmd.mul) begin
			prod_s1 <= 64'(dabs[cmd.adv]) * 64'(len_q);
		end
	end

	assign sts.walk_active = active_q;
	assign sts.srch_done   = &sdone;
	assign sts.div_done    = &ldone;

endmodule

// ----- rtl/rgrt_ctrl.sv -----
`timescale 1ns / 1ps
module rgrt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     action,
	input  rgrt_pkg::sts_t sts,
	output rgrt_pkg::cmd_t cmd,
	output logic           busy
);

	rgrt_pkg::state_t state_q;
	rgrt_pkg::state_t state_d;
	logic [1:0]       adv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgrt_pkg::ST_IDLE;
			adv_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rgrt_pkg::ST_SEL) begin
				adv_q <= '0;
			end else if (state_q == rgrt_pkg::ST_ADD) begin
				adv_q <= (adv_q == 2'd2) ? 2'd0 : adv_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rgrt_pkg::ST_IDLE: begin
				if (start) begin
					if (action == rgrt_pkg::ACT_START) begin
						state_d = rgrt_pkg::ST_SRD;
					end else if (action == rgrt_pkg::ACT_STEP && sts.walk_active) begin
						state_d = rgrt_pkg::ST_CLAMP;
					end
				end
			end
			rgrt_pkg::ST_SRD:   state_d = sts.srch_done ? rgrt_pkg::ST_IDLE : rgrt_pkg::ST_SCMP;
			rgrt_pkg::ST_SCMP:  state_d = rgrt_pkg::ST_SRD;
			rgrt_pkg::ST_CLAMP: state_d = rgrt_pkg::ST_WRD;
			rgrt_pkg::ST_WRD:   state_d = rgrt_pkg::ST_DIVGO;
			rgrt_pkg::ST_DIVGO: state_d = rgrt_pkg::ST_DIVW;
			rgrt_pkg::ST_DIVW:  state_d = sts.div_done ? rgrt_pkg::ST_SEL : rgrt_pkg::ST_DIVW;
			rgrt_pkg::ST_SEL:   state_d = rgrt_pkg::ST_MUL;
			rgrt_pkg::ST_MUL:   state_d = rgrt_pkg::ST_ADD;
			rgrt_pkg::ST_ADD:   state_d = (adv_q == 2'd2) ? rgrt_pkg::ST_IDLE : rgrt_pkg::ST_MUL;
			default:            state_d = rgrt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.adv = adv_q;
		case (state_q)
			rgrt_pkg::ST_IDLE: begin
				if (start) begin
					if (action == rgrt_pkg::ACT_START) begin
						cmd.accept_start = 1'b1;
					end else if (!(action == rgrt_pkg::ACT_STEP && sts.walk_active)) begin
						cmd.accept_load = (action == rgrt_pkg::ACT_LOAD);
						cmd.emit_zero   = 1'b1;
					end
				end
			end
			rgrt_pkg::ST_SRD: begin
				if (sts.srch_done) begin
					cmd.srch_fin  = 1'b1;
					cmd.emit_zero = 1'b1;
				end else begin
					cmd.srch_rd = 1'b1;
				end
			end
			rgrt_pkg::ST_SCMP:  cmd.srch_cmp = 1'b1;
			rgrt_pkg::ST_CLAMP: cmd.clamp = 1'b1;
			rgrt_pkg::ST_DIVGO: cmd.div_go = 1'b1;
			rgrt_pkg::ST_SEL:   cmd.sel = 1'b1;
			rgrt_pkg::ST_MUL:   cmd.mul = 1'b1;
			rgrt_pkg::ST_ADD:   cmd.add = 1'b1;
			default:            cmd.adv = adv_q;
		endcase
	end

	assign busy = (state_q != rgrt_pkg::ST_IDLE);

endmodule

// ----- rtl/rectilinear_grid_ray_traversal_core.sv -----
`timescale 1ns / 1ps
// Load, idle step and unknown action: result in the cycle after accept, when the next beat may be taken.
// Start: three parallel binary searches, one edge read per probe; the result is strobed
//   once all three searches are done.
// Step: a bit-serial divider per axis, then the result, then position update of each axis
//   in turn on one shared multiplier; no new beat is taken until the update is done.
// Results are strobed on done for one cycle; the receiver cannot stall.
// arst_n clears control, ray state and cell counts (to 1); edge memories are not cleared.
module rectilinear_grid_ray_traversal_core #(
	parameter int MAX_CELLS_PER_AXIS = rgrt_pkg::MAX_CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [1:0]  axis,
	input  logic [6:0]  edge_slot,
	input  logic [31:0] edge_coord,
	input  logic [31:0] start_x,
	input  logic [31:0] start_y,
	input  logic [31:0] start_z,
	input  logic [31:0] dir_x,
	input  logic [31:0] dir_y,
	input  logic [31:0] dir_z,
	output logic        done,
	output logic        segment_valid,
	output logic [17:0] cell_number,
	output logic [31:0] segment_length,
	output logic        exited
);

	logic [rgrt_pkg::CFG_W-1:0] cells_x_q;
	logic [rgrt_pkg::CFG_W-1:0] cells_y_q;
	logic [rgrt_pkg::CFG_W-1:0] cells_z_q;
	logic                       wr;
	rgrt_pkg::cmd_t             cmd;
	rgrt_pkg::sts_t             sts;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= rgrt_pkg::CFG_W'(1);
			cells_y_q <= rgrt_pkg::CFG_W'(1);
			cells_z_q <= rgrt_pkg::CFG_W'(1);
		end else if (wr) begin
			case (paddr[3:2])
				rgrt_pkg::REG_CELLS_X: cells_x_q <= pwdata[rgrt_pkg::CFG_W-1:0];
				rgrt_pkg::REG_CELLS_Y: cells_y_q <= pwdata[rgrt_pkg::CFG_W-1:0];
				rgrt_pkg::REG_CELLS_Z: cells_z_q <= pwdata[rgrt_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rgrt_pkg::REG_CELLS_X: prdata = 32'(cells_x_q);
			rgrt_pkg::REG_CELLS_Y: prdata = 32'(cells_y_q);
			rgrt_pkg::REG_CELLS_Z: prdata = 32'(cells_z_q);
			default:               prdata = '0;
		endcase
	end

	rgrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rgrt_dp #(
		.N (MAX_CELLS_PER_AXIS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cells_x        (cells_x_q),
		.cells_y        (cells_y_q),
		.cells_z        (cells_z_q),
		.axis           (axis),
		.edge_slot      (edge_slot),
		.edge_coord     (edge_coord),
		.start_x        (start_x),
		.start_y        (start_y),
		.start_z        (start_z),
		.dir_x          (dir_x),
		.dir_y          (dir_y),
		.dir_z          (dir_z),
		.done           (done),
		.segment_valid  (segment_valid),
		.cell_number    (cell_number),
		.segment_length (segment_length),
		.exited         (exited)
	);

endmodule

// ----- rtl/rgrt_chk.sv -----
`timescale 1ns / 1ps
module rgrt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        segment_valid,
	input logic [17:0] cell_number,
	input logic [31:0] segment_length,
	input logic        exited
);

	a_exit_has_seg: assert property (@(posedge clk) disable iff (!arst_n)
		done && exited |-> segment_valid)
		else $error("exit beat without a segment");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result beat with no work in flight");

	a_zero_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done && !segment_valid |-> cell_number == '0 && segment_length == '0 && !exited)
		else $error("non-segment beat carries data");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted beat");

endmodule

bind rectilinear_grid_ray_traversal_core rgrt_chk u_chk (.*);

// ----- test/rectilinear_grid_ray_traversal_core_tb.sv -----
`timescale 1ns / 1ps
module rectilinear_grid_ray_traversal_core_tb;

	localparam int MAXC = rgrt_pkg::MAX_CELLS_DEF;
	localparam int LIMIT = 3000000;
	localparam int RANDOM_BEATS = 1000;

	typedef struct packed {
		logic [1:0]       act;
		logic [1:0]       ax;
		logic [6:0]       slot;
		logic [31:0]      coord;
		logic [2:0][31:0] pos;
		logic [2:0][31:0] dir;
	} beat_t;

	typedef struct packed {
		logic        seg;
		logic [17:0] cnum;
		logic [31:0] len;
		logic        ex;
	} seg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = '0;
	logic [1:0]  axis = '0;
	logic [6:0]  edge_slot = '0;
	logic [31:0] edge_coord = '0;
	logic [31:0] start_x = '0;
	logic [31:0] start_y = '0;
	logic [31:0] start_z = '0;
	logic [31:0] dir_x = '0;
	logic [31:0] dir_y = '0;
	logic [31:0] dir_z = '0;
	logic        done;
	logic        segment_valid;
	logic [17:0] cell_number;
	logic [31:0] segment_length;
	logic        exited;

	rectilinear_grid_ray_traversal_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.action(action), .axis(axis), .edge_slot(edge_slot), .edge_coord(edge_coord),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.done(done), .segment_valid(segment_valid), .cell_number(cell_number),
		.segment_length(segment_length), .exited(exited)
	);

	always #1 clk = ~clk;

	// walker state as the block should hold it
	logic [31:0] edge_mem [3][MAXC+1];
	logic [31:0] ray_pos [3];
	logic [31:0] ray_dir [3];
	int unsigned cell_idx [3];
	bit          walking;
	logic [6:0]  cell_cfg [3];

	// generator's view of the edges and counts
	longint      gen_edge [3][MAXC+1];
	int unsigned gen_cells [3];

	beat_t beats[$];
	seg_t  segs_due[$];
	beat_t cur;
	int    gap_left;
	bit    idle_on;
	int    errors, n_beats, n_segs, n_exits, n_sat, cycles;

	function automatic longint sx(logic [31:0] v);
		longint t;
		t = $signed(v);
		return t;
	endfunction

	function automatic int unsigned eff_cells(int a);
		if (cell_cfg[a] == 0) return 1;
		if (cell_cfg[a] > MAXC) return MAXC;
		return cell_cfg[a];
	endfunction

	function automatic int unsigned find_cell(int a, int unsigned n, longint p);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = n;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (p < sx(edge_mem[a][mid])) hi = mid;
			else lo = mid;
		end
		return lo;
	endfunction

	function automatic logic [31:0] wall_dist(longint wall, longint p, longint k);
		longint diff;
		longint unsigned mag, den, q;
		if (k == 0) return rgrt_pkg::MAX_LEN;
		diff = wall - p;
		if (diff == 0 || ((diff < 0) != (k < 0))) return '0;
		mag = diff < 0 ? -diff : diff;
		den = k < 0 ? -k : k;
		q = (mag << 30) / den;
		return q > 64'hFFFF_FFFF ? rgrt_pkg::MAX_LEN : q[31:0];
	endfunction

	function automatic logic [31:0] move_along(longint p, longint k, logic [31:0] len);
		longint unsigned d;
		longint r;
		d = ((k < 0 ? -k : k) * longint'({32'd0, len})) >> 30;
		r = k < 0 ? p - longint'(d) : p + longint'(d);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic seg_t walk_beat(beat_t b);
		seg_t r;
		int unsigned n [3];
		logic [31:0] len [3];
		longint wall [3];
		longint k [3];
		int sel;
		int unsigned c;
		r = '0;
		case (b.act)
			rgrt_pkg::ACT_LOAD: begin
				if (b.ax < 3 && b.slot <= MAXC) edge_mem[b.ax][b.slot] = b.coord;
			end
			rgrt_pkg::ACT_START: begin
				for (int a = 0; a < 3; a++) begin
					ray_pos[a] = b.pos[a];
					ray_dir[a] = b.dir[a];
					cell_idx[a] = find_cell(a, eff_cells(a), sx(b.pos[a]));
				end
				walking = 1'b1;
			end
			rgrt_pkg::ACT_STEP: begin
				if (walking) begin
					for (int a = 0; a < 3; a++) begin
						n[a] = eff_cells(a);
						if (cell_idx[a] >= n[a]) cell_idx[a] = n[a] - 1;
						k[a] = sx(ray_dir[a]);
						wall[a] = sx(k[a] < 0 ? edge_mem[a][cell_idx[a]] :
							edge_mem[a][cell_idx[a] + 1]);
						len[a] = wall_dist(wall[a], sx(ray_pos[a]), k[a]);
					end
					if (len[0] <= len[1] && len[0] <= len[2]) sel = 0;
					else if (len[1] < len[0] && len[1] <= len[2]) sel = 1;
					else sel = 2;
					c = cell_idx[2] + n[2] * cell_idx[1] + n[2] * n[1] * cell_idx[0];
					r.seg = 1'b1;
					r.cnum = c[17:0];
					r.len = len[sel];
					for (int a = 0; a < 3; a++) begin
						if (a == sel) ray_pos[a] = wall[a][31:0];
						else ray_pos[a] = move_along(sx(ray_pos[a]), k[a], len[sel]);
					end
					if (k[sel] < 0) begin
						if (cell_idx[sel] == 0) begin
							walking = 1'b0;
							r.ex = 1'b1;
						end else cell_idx[sel]--;
					end else begin
						if (cell_idx[sel] + 1 >= n[sel]) begin
							walking = 1'b0;
							r.ex = 1'b1;
						end else cell_idx[sel]++;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit took;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			took = start && !busy;
			if (took) begin
				segs_due.push_back(walk_beat(cur));
				n_beats++;
				if (idle_on) gap_left = pick_gap();
			end
			if (start && !took) begin
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (beats.size() > 0) begin
				cur = beats.pop_front();
				action <= cur.act;
				axis <= cur.ax;
				edge_slot <= cur.slot;
				edge_coord <= cur.coord;
				start_x <= cur.pos[0];
				start_y <= cur.pos[1];
				start_z <= cur.pos[2];
				dir_x <= cur.dir[0];
				dir_y <= cur.dir[1];
				dir_z <= cur.dir[2];
				start <= 1'b1;
			end else start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		seg_t e;
		if (arst_n && done) begin
			if (segs_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat: cell %0d len %h",
					cell_number, segment_length);
			end else begin
				e = segs_due.pop_front();
				if (e.seg) n_segs++;
				if (e.ex) n_exits++;
				if (e.seg && e.len == rgrt_pkg::MAX_LEN) n_sat++;
				if (segment_valid !== e.seg || cell_number !== e.cnum ||
						segment_length !== e.len || exited !== e.ex) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp v%0b c%0d l%h x%0b, got v%0b c%0d l%h x%0b",
							e.seg, e.cnum, e.len, e.ex, segment_valid, cell_number,
							segment_length, exited);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout with %0d results outstanding", segs_due.size());
			$display("FAIL rectilinear_grid_ray_traversal_core");
			$finish;
		end
	end

	function automatic beat_t rand_beat();
		beat_t b;
		b.act = 2'($urandom_range(0, 3));
		b.ax = 2'($urandom_range(0, 3));
		b.slot = 7'($urandom_range(0, 127));
		b.coord = $urandom;
		for (int a = 0; a < 3; a++) begin
			b.pos[a] = $urandom;
			b.dir[a] = $urandom;
		end
		return b;
	endfunction

	function automatic logic [31:0] rand_dir();
		int r;
		longint d;
		r = $urandom_range(0, 99);
		if (r < 8) d = 0;
		else if (r < 15) d = $urandom_range(1, 15);
		else if (r < 22) d = 64'sd1073741824;
		else d = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
		if (r >= 8 && r < 22 && $urandom_range(0, 1)) d = -d;
		return d[31:0];
	endfunction

	task automatic push_load(int a, int s, longint v);
		beat_t b;
		b = rand_beat();
		b.act = rgrt_pkg::ACT_LOAD;
		b.ax = 2'(a);
		b.slot = 7'(s);
		b.coord = v[31:0];
		if (a < 3 && s <= MAXC) gen_edge[a][s] = sx(v[31:0]);
		beats.push_back(b);
	endtask

	task automatic push_start(longint px, longint py, longint pz,
			logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
		beat_t b;
		b = rand_beat();
		b.act = rgrt_pkg::ACT_START;
		b.pos[0] = px[31:0];
		b.pos[1] = py[31:0];
		b.pos[2] = pz[31:0];
		b.dir[0] = dx;
		b.dir[1] = dy;
		b.dir[2] = dz;
		beats.push_back(b);
	endtask

	task automatic push_steps(int cnt);
		beat_t b;
		for (int i = 0; i < cnt; i++) begin
			b = rand_beat();
			b.act = rgrt_pkg::ACT_STEP;
			beats.push_back(b);
		end
	endtask

	task automatic fill_axis(int a, int upto, longint spacing_max);
		longint v;
		v = -longint'($urandom_range(0, 32'h3000_0000));
		for (int i = 0; i <= upto; i++) begin
			push_load(a, i, v);
			v += $urandom_range(1, spacing_max);
		end
	endtask

	task automatic drain();
		do @(posedge clk); while (beats.size() != 0 || start || segs_due.size() != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, int unsigned val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cell_cfg[idx] = val[6:0];
		gen_cells[idx] = eff_cells(idx);
	endtask

	task automatic set_cells(int unsigned cx, int unsigned cy, int unsigned cz);
		reg_write(rgrt_pkg::REG_CELLS_X, cx);
		reg_write(rgrt_pkg::REG_CELLS_Y, cy);
		reg_write(rgrt_pkg::REG_CELLS_Z, cz);
	endtask

	function automatic longint pos_in(int a);
		int unsigned c;
		longint lo, hi;
		c = $urandom_range(0, gen_cells[a] - 1);
		lo = gen_edge[a][c];
		hi = gen_edge[a][c + 1];
		if (hi <= lo) return lo;
		return lo + longint'($urandom) % (hi - lo);
	endfunction

	task automatic random_phase(int quota);
		int r, cnt;
		longint p [3];
		beat_t b;
		cnt = 0;
		while (cnt < quota) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				for (int a = 0; a < 3; a++)
					p[a] = ($urandom_range(0, 9) == 0) ? sx($urandom) : pos_in(a);
				push_start(p[0], p[1], p[2], rand_dir(), rand_dir(), rand_dir());
				r = $urandom_range(1, gen_cells[0] + gen_cells[1] + gen_cells[2] + 4);
				if (r > 60) r = $urandom_range(1, 60);
				push_steps(r);
				cnt += r + 1;
			end else if (r < 88) begin
				push_load($urandom_range(0, 2), $urandom_range(0, MAXC), sx($urandom));
				cnt++;
			end else if (r < 93) begin
				b = rand_beat();
				if (b.act == rgrt_pkg::ACT_LOAD) begin
					b.ax = 2'd3;
				end
				if (b.act == rgrt_pkg::ACT_START) b.act = 2'd3;
				beats.push_back(b);
				cnt++;
			end else begin
				push_steps($urandom_range(1, 4));
				cnt++;
			end
		end
	endtask

	initial begin
		int unsigned cfg [7][3];
		cfg = '{'{1, 1, 1}, '{64, 64, 64}, '{0, 127, 5}, '{64, 1, 64},
			'{0, 0, 0}, '{1, 1, 1}, '{1, 1, 1}};
		for (int i = 5; i < 7; i++)
			for (int a = 0; a < 3; a++) cfg[i][a] = $urandom_range(1, 64);
		for (int a = 0; a < 3; a++) begin
			cell_cfg[a] = 7'd1;
			gen_cells[a] = 1;
			cell_idx[a] = 0;
			ray_pos[a] = '0;
			ray_dir[a] = '0;
		end
		walking = 1'b0;
		idle_on = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// uniform unit grid on all axes: ties are exact
		push_steps(1);
		for (int a = 0; a < 3; a++)
			for (int i = 0; i <= MAXC; i++) push_load(a, i, longint'(i) << 16);
		drain();
		set_cells(4, 4, 4);
		push_load(3, 5, 32'h1234_5678);
		push_load(0, 127, 32'h7FFF_FFFF);
		push_load(1, 65, 32'h8000_0000);
		begin
			beat_t b;
			b = rand_beat();
			b.act = 2'd3;
			beats.push_back(b);
		end
		push_start(32'h8000, 32'h8000, 32'h8000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000);
		push_steps(11);
		push_start(32'h18000, 32'h18000, 32'h18000, 32'h0, 32'h0, 32'h0);
		push_steps(2);
		push_start(-64'sd2147483648, 64'sd2147483647, 32'h8000,
			32'h4000_0000, 32'hC000_0000, 32'hC000_0000);
		push_steps(2);
		push_start(32'h2_8000, 32'h1_0000, 32'h8000, 32'h1, 32'hFFFF_FFFF, 32'h0);
		push_steps(2);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			idle_on = (ph != 3);
			set_cells(cfg[ph][0], cfg[ph][1], cfg[ph][2]);
			for (int a = 0; a < 3; a++)
				if (ph > 0) fill_axis(a, gen_cells[a],
					(ph % 2) ? 64'd16777216 : longint'($urandom_range(2, 1 << 20)));
			random_phase(RANDOM_BEATS / 7);
			drain();
		end
		repeat (50) @(posedge clk);
		$display("%0d beats accepted, %0d segments walked, %0d exits, %0d saturated lengths",
			n_beats, n_segs, n_exits, n_sat);
		$display("eight cell-count settings incl. 0, 1, 64 and 127; %0d mismatches", errors);
		if (errors == 0) begin
			$display("PASS rectilinear_grid_ray_traversal_core");
		end else begin
			$display("FAIL rectilinear_grid_ray_traversal_core");
		end
		$finish;
	end

endmodule
